// File: design/pbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_pkg
// Shared constants and types for the perceptron branch predictor.
// ----------------------------------------------------------------------------
package pbp_pkg;

	localparam int NUM_WEIGHTS_DEF = 32;
	localparam int HIST_W          = 32;
	localparam int WEIGHT_W        = 8;
	localparam int LIMIT_W         = 7;
	localparam int SUM_OUT_W       = 13;
	localparam int THR_W           = 13;
	localparam int APB_ADDR_W      = 3;
	localparam int APB_DATA_W      = 32;

	localparam logic REQ_PREDICT = 1'b0;
	localparam logic REQ_TRAIN   = 1'b1;

	localparam logic REG_WEIGHT_LIMIT    = 1'b0;
	localparam logic REG_TRAIN_THRESHOLD = 1'b1;

	localparam logic [LIMIT_W-1:0] WEIGHT_LIMIT_RST    = 7'd127;
	localparam logic [THR_W-1:0]   TRAIN_THRESHOLD_RST = 13'd0;

	typedef logic signed [WEIGHT_W-1:0] weight_t;

	typedef struct packed {
		logic                 hist_bit;
		logic                 outcome;
		logic [LIMIT_W-1:0]   limit;
	} alu_ctl_t;

endpackage
`default_nettype wire

// File: design/pbp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_req_if / pbp_rsp_if
// Valid/ready channels carrying predictor requests and results.
// ----------------------------------------------------------------------------
interface pbp_req_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     req_type;
	logic [pbp_pkg::HIST_W-1:0]               history_bits;
	logic                                     outcome_taken;
	logic signed [pbp_pkg::SUM_OUT_W-1:0]     earlier_sum;

	modport source(output valid, req_type, history_bits, outcome_taken, earlier_sum,
		input ready);
	modport sink(input valid, req_type, history_bits, outcome_taken, earlier_sum,
		output ready);
endinterface

interface pbp_rsp_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [pbp_pkg::SUM_OUT_W-1:0]     dot_sum;
	logic                                     predict_taken;
	logic                                     weights_updated;

	modport source(output valid, dot_sum, predict_taken, weights_updated, input ready);
	modport sink(input valid, dot_sum, predict_taken, weights_updated, output ready);
endinterface
`default_nettype wire

// File: design/pbp_weight_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_weight_alu
// Per-weight arithmetic: signed product term and saturating training update.
// ----------------------------------------------------------------------------
module pbp_weight_alu (
	input  wire  pbp_pkg::weight_t  weight,
	input  wire  pbp_pkg::alu_ctl_t ctl,
	output pbp_pkg::weight_t        term,
	output pbp_pkg::weight_t        new_weight
);

	logic signed [pbp_pkg::WEIGHT_W:0] upd;
	logic signed [pbp_pkg::WEIGHT_W:0] lim_pos;
	logic signed [pbp_pkg::WEIGHT_W:0] lim_neg;
	logic signed [pbp_pkg::WEIGHT_W:0] clamped;

	// weights stay within +/-127, so negation never overflows
	assign term = ctl.hist_bit ? weight : -weight;

	assign lim_pos = $signed({2'b00, ctl.limit});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (ctl.hist_bit == ctl.outcome) begin
			upd = {weight[pbp_pkg::WEIGHT_W-1], weight} + 9'sd1;
		end else begin
			upd = {weight[pbp_pkg::WEIGHT_W-1], weight} - 9'sd1;
		end
		if (upd > lim_pos) begin
			clamped = lim_pos;
		end else if (upd < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = upd;
		end
	end

	assign new_weight = clamped[pbp_pkg::WEIGHT_W-1:0];

endmodule
`default_nettype wire

// File: design/perceptron_branch_predictor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perceptron_branch_predictor_core
// Single perceptron predictor with its weights in a synchronous RAM.
//
// req channel: predict (dot product of weights and +/-1 history) or train.
// rsp channel: one result per request: dot_sum, predict_taken,
//   weights_updated. APB port: weight_limit at 0x0, train_threshold at 0x4.
// Each predict or applied train sweeps the weight RAM, one entry per cycle
// through a single read port and one update ALU; a train that is not applied
// skips the sweep. One request is in flight at a time;
// req.ready is high whenever no request is in flight.
// The result sits in an output register, so a new request is taken while
// the previous result waits; a result that finishes while the receiver
// still stalls is held until the output register frees.
// Reset clears all weights at once through per-entry valid bits (no
// clearing pass) and restores the register defaults.
// ----------------------------------------------------------------------------
module perceptron_branch_predictor_core #(
	parameter int NUM_WEIGHTS = pbp_pkg::NUM_WEIGHTS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	pbp_req_if.sink                             req,
	pbp_rsp_if.source                           rsp,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [pbp_pkg::APB_ADDR_W-1:0]      paddr,
	input  wire  [pbp_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [pbp_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int IDX_W  = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
	localparam int ACC_W  = $clog2(NUM_WEIGHTS * 128) + 1;
	localparam int SUM_W  = (ACC_W > pbp_pkg::SUM_OUT_W) ? ACC_W : pbp_pkg::SUM_OUT_W;
	localparam int OUT_W  = pbp_pkg::SUM_OUT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WEIGHTS - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic [pbp_pkg::LIMIT_W-1:0] weight_limit_q;
	logic [pbp_pkg::THR_W-1:0]   train_threshold_q;

	// request latches
	logic [pbp_pkg::HIST_W-1:0]  hist_q;
	logic                        train_q;
	logic                        outcome_q;
	logic                        apply_q;

	// weight store
	pbp_pkg::weight_t            mem [NUM_WEIGHTS];
	logic [NUM_WEIGHTS-1:0]      wvalid_q;
	logic [IDX_W-1:0]            rd_idx_q;
	logic                        rd_en;

	logic                        rd_v_s1;
	logic [IDX_W-1:0]            idx_s1;
	pbp_pkg::weight_t            rd_data_s1;
	logic                        wvld_s1;

	logic signed [SUM_W-1:0]     acc_q;

	logic [NUM_WEIGHTS-1:0]      hist_ext;
	pbp_pkg::weight_t            cur_w;
	pbp_pkg::weight_t            term;
	pbp_pkg::weight_t            new_w;
	pbp_pkg::alu_ctl_t           alu_ctl;
	logic                        wr_en;

	logic                        req_xfer;
	logic                        out_free;
	logic                        early_pred;
	logic [OUT_W:0]              early_mag;
	logic                        apply_d;

	logic                        rsp_valid_q;
	logic signed [OUT_W-1:0]     rsp_sum_q;
	logic                        rsp_taken_q;
	logic                        rsp_upd_q;
	logic signed [OUT_W-1:0]     sum_sat;

	logic                        cfg_wr;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_limit_q    <= pbp_pkg::WEIGHT_LIMIT_RST;
			train_threshold_q <= pbp_pkg::TRAIN_THRESHOLD_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				pbp_pkg::REG_WEIGHT_LIMIT:    weight_limit_q    <= pwdata[pbp_pkg::LIMIT_W-1:0];
				pbp_pkg::REG_TRAIN_THRESHOLD: train_threshold_q <= pwdata[pbp_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pbp_pkg::REG_WEIGHT_LIMIT:
				prdata = {{(pbp_pkg::APB_DATA_W - pbp_pkg::LIMIT_W){1'b0}}, weight_limit_q};
			pbp_pkg::REG_TRAIN_THRESHOLD:
				prdata = {{(pbp_pkg::APB_DATA_W - pbp_pkg::THR_W){1'b0}}, train_threshold_q};
			default:
				prdata = '0;
		endcase
	end

	// ---------------- request intake ----------------
	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;

	assign early_pred = !req.earlier_sum[OUT_W-1];
	assign early_mag  = req.earlier_sum[OUT_W-1] ?
		(OUT_W+1)'(-$signed({req.earlier_sum[OUT_W-1], req.earlier_sum})) :
		{1'b0, req.earlier_sum};
	assign apply_d = (early_pred != req.outcome_taken) ||
		(early_mag <= {1'b0, train_threshold_q});

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			hist_q    <= req.history_bits;
			train_q   <= (req.req_type == pbp_pkg::REQ_TRAIN);
			outcome_q <= req.outcome_taken;
			apply_q   <= apply_d;
		end
	end

	// elements past the history width count as -1
	for (genvar i = 0; i < NUM_WEIGHTS; i++) begin : g_hist
		if (i < pbp_pkg::HIST_W) begin : g_in
			assign hist_ext[i] = hist_q[i];
		end else begin : g_out
			assign hist_ext[i] = 1'b0;
		end
	end

	// ---------------- sequencer ----------------
	assign out_free = !rsp_valid_q || rsp.ready;
	assign rd_en    = (state_q == ST_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						rd_idx_q <= '0;
						if (req.req_type == pbp_pkg::REQ_TRAIN && !apply_d) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------- weight RAM ----------------
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
		if (wr_en) begin
			mem[idx_s1] <= new_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			rd_v_s1  <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (wr_en) begin
				wvalid_q[idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1  <= rd_idx_q;
			wvld_s1 <= wvalid_q[rd_idx_q];
		end
	end

	// ---------------- read-modify-write stage ----------------
	assign cur_w           = wvld_s1 ? rd_data_s1 : '0;
	assign alu_ctl.hist_bit = hist_ext[idx_s1];
	assign alu_ctl.outcome  = outcome_q;
	assign alu_ctl.limit    = weight_limit_q;
	assign wr_en           = rd_v_s1 && train_q;

	pbp_weight_alu u_alu (
		.weight     (cur_w),
		.ctl        (alu_ctl),
		.term       (term),
		.new_weight (new_w)
	);

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			acc_q <= '0;
		end else if (rd_v_s1 && !train_q) begin
			acc_q <= acc_q + SUM_W'(term);
		end
	end

	// ---------------- result register ----------------
	always_comb begin
		if (acc_q > SUM_W'(4095)) begin
			sum_sat = 13'sd4095;
		end else if (acc_q < -SUM_W'(4096)) begin
			sum_sat = -13'sd4096;
		end else begin
			sum_sat = acc_q[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp_sum_q   <= train_q ? '0 : sum_sat;
			rsp_taken_q <= !train_q && !acc_q[SUM_W-1];
			rsp_upd_q   <= train_q && apply_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.dot_sum         = rsp_sum_q;
	assign rsp.predict_taken   = rsp_taken_q;
	assign rsp.weights_updated = rsp_upd_q;

endmodule
`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for perceptron_branch_predictor_core.
//
// A shadow weight bank is updated on every request transfer and produces the
// result each request should return. The results are queued in order and
// compared field by field as they leave the block. A short directed run
// covers the field extremes, saturation and a lowered weight limit. Random
// phases under several register settings follow. Most random traffic is
// predict/train pairs on a small pool of histories, with the train reusing
// the predicted sum. Both channels idle at random, and one phase holds the
// result channel off long enough to back up the request channel.
// ----------------------------------------------------------------------------
module tb;

	localparam int NW          = pbp_pkg::NUM_WEIGHTS_DEF;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic                                 req_type;
		logic [pbp_pkg::HIST_W-1:0]           history;
		logic                                 outcome;
		logic signed [pbp_pkg::SUM_OUT_W-1:0] earlier;
		bit                                   reuse_sum;
	} branch_req_t;

	typedef struct {
		logic signed [pbp_pkg::SUM_OUT_W-1:0] dot_sum;
		logic                                 predict_taken;
		logic                                 weights_updated;
	} branch_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [pbp_pkg::APB_ADDR_W-1:0] paddr;
	logic [pbp_pkg::APB_DATA_W-1:0] pwdata;
	logic [pbp_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	pbp_req_if req_ch();
	pbp_rsp_if rsp_ch();

	perceptron_branch_predictor_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	pbp_pkg::weight_t             shadow_weights [NW];
	logic [pbp_pkg::LIMIT_W-1:0]  limit_shadow;
	logic [pbp_pkg::THR_W-1:0]    thr_shadow;

	branch_req_t    staged_reqs [$];
	branch_result_t awaited_results [$];
	branch_req_t    cur_req;

	int  tx_gap;
	int  rx_gap;
	int  hold_left;
	logic hold_arm;
	bit  idle_on;
	int  mismatch_cnt = 0;
	int  cycle_cnt = 0;

	always #5 clk = ~clk;

	function automatic int pick_gap();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
	endfunction

	function automatic int rand_earlier();
		return int'($urandom_range(0, 8128)) - 4064;
	endfunction

	function automatic int score_history(logic [pbp_pkg::HIST_W-1:0] hist);
		int acc;
		acc = 0;
		for (int i = 0; i < NW; i++) begin
			if (i < pbp_pkg::HIST_W && hist[i])
				acc += shadow_weights[i];
			else
				acc -= shadow_weights[i];
		end
		return acc;
	endfunction

	function automatic logic signed [pbp_pkg::SUM_OUT_W-1:0] clamp_sum(int v);
		int c;
		c = v;
		if (c > 4095)
			c = 4095;
		if (c < -4096)
			c = -4096;
		return c[pbp_pkg::SUM_OUT_W-1:0];
	endfunction

	function automatic void stage(logic kind, logic [pbp_pkg::HIST_W-1:0] hist, logic taken,
		int earlier, bit reuse);
		branch_req_t r;
		r.req_type  = kind;
		r.history   = hist;
		r.outcome   = taken;
		r.earlier   = earlier[pbp_pkg::SUM_OUT_W-1:0];
		r.reuse_sum = reuse;
		staged_reqs.push_back(r);
	endfunction

	// advance the shadow bank by one request and queue its result
	function automatic void absorb_request(branch_req_t r);
		branch_result_t res;
		int sum;
		int guess;
		int dir;
		int mag;
		int lim;
		int w;
		bit apply;
		res.dot_sum         = '0;
		res.predict_taken   = 1'b0;
		res.weights_updated = 1'b0;
		if (r.req_type == pbp_pkg::REQ_PREDICT) begin
			sum = score_history(r.history);
			res.dot_sum       = clamp_sum(sum);
			res.predict_taken = (sum >= 0);
		end else begin
			guess = (r.earlier >= 0) ? 1 : -1;
			dir   = r.outcome ? 1 : -1;
			mag   = (r.earlier < 0) ? -int'(r.earlier) : int'(r.earlier);
			apply = (guess != dir) || (mag <= int'(thr_shadow));
			if (apply) begin
				lim = int'(limit_shadow);
				for (int i = 0; i < NW; i++) begin
					w = shadow_weights[i] +
						((i < pbp_pkg::HIST_W && r.history[i]) ? dir : -dir);
					if (w > lim)
						w = lim;
					if (w < -lim)
						w = -lim;
					shadow_weights[i] = pbp_pkg::weight_t'(w);
				end
			end
			res.weights_updated = apply;
		end
		awaited_results.push_back(res);
	endfunction

	task automatic write_reg(logic idx, int value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == pbp_pkg::REG_WEIGHT_LIMIT)
			limit_shadow = value[pbp_pkg::LIMIT_W-1:0];
		else
			thr_shadow = value[pbp_pkg::THR_W-1:0];
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (staged_reqs.size() != 0 || req_ch.valid || awaited_results.size() != 0);
	endtask

	// request driver
	always @(posedge clk) begin
		branch_req_t nxt;
		bit offering;
		if (!arst_n) begin
			req_ch.valid         <= 1'b0;
			req_ch.req_type      <= pbp_pkg::REQ_PREDICT;
			req_ch.history_bits  <= '0;
			req_ch.outcome_taken <= 1'b0;
			req_ch.earlier_sum   <= '0;
			tx_gap <= 0;
		end else begin
			offering = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				absorb_request(cur_req);
				offering = 1'b0;
			end
			if (!offering) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					req_ch.valid <= 1'b0;
				end else if (staged_reqs.size() != 0) begin
					nxt = staged_reqs.pop_front();
					if (nxt.reuse_sum)
						nxt.earlier = clamp_sum(score_history(nxt.history));
					cur_req = nxt;
					req_ch.valid         <= 1'b1;
					req_ch.req_type      <= nxt.req_type;
					req_ch.history_bits  <= nxt.history;
					req_ch.outcome_taken <= nxt.outcome;
					req_ch.earlier_sum   <= nxt.earlier;
					tx_gap <= idle_on ? pick_gap() : 0;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_arm)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result monitor
	always @(posedge clk) begin
		branch_result_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with no request outstanding");
					mismatch_cnt++;
				end else begin
					want = awaited_results.pop_front();
					if (rsp_ch.dot_sum !== want.dot_sum) begin
						$error("dot_sum: expected %0d, got %0d", want.dot_sum, rsp_ch.dot_sum);
						mismatch_cnt++;
					end
					if (rsp_ch.predict_taken !== want.predict_taken) begin
						$error("predict_taken: expected %0b, got %0b",
							want.predict_taken, rsp_ch.predict_taken);
						mismatch_cnt++;
					end
					if (rsp_ch.weights_updated !== want.weights_updated) begin
						$error("weights_updated: expected %0b, got %0b",
							want.weights_updated, rsp_ch.weights_updated);
						mismatch_cnt++;
					end
				end
			end
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
			end else if (rx_gap != 0) begin
				rsp_ch.ready <= 1'b0;
				rx_gap <= rx_gap - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 3) == 0)
					rx_gap <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int lim_plan [8];
		int thr_plan [8];
		logic [pbp_pkg::HIST_W-1:0] pool [4];
		int made;
		int slot;
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		hold_arm <= 1'b0;
		idle_on = 1'b0;
		limit_shadow = pbp_pkg::WEIGHT_LIMIT_RST;
		thr_shadow   = pbp_pkg::TRAIN_THRESHOLD_RST;
		foreach (shadow_weights[i])
			shadow_weights[i] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: empty bank, exact-match and mispredict trains
		stage(pbp_pkg::REQ_PREDICT, 32'h0000_0000, 1'b0, 0, 1'b0);
		stage(pbp_pkg::REQ_PREDICT, 32'hFFFF_FFFF, 1'b1, -4064, 1'b0);
		stage(pbp_pkg::REQ_TRAIN, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
		stage(pbp_pkg::REQ_TRAIN, 32'hFFFF_FFFF, 1'b1, 1, 1'b0);
		stage(pbp_pkg::REQ_TRAIN, 32'h0000_0000, 1'b0, 4064, 1'b0);
		stage(pbp_pkg::REQ_TRAIN, 32'hAAAA_AAAA, 1'b1, -4064, 1'b0);
		stage(pbp_pkg::REQ_TRAIN, 32'h5555_5555, 1'b0, -1, 1'b0);
		stage(pbp_pkg::REQ_PREDICT, 32'hAAAA_AAAA, 1'b0, 4064, 1'b0);
		stage(pbp_pkg::REQ_PREDICT, 32'h5555_5555, 1'b1, -1, 1'b0);
		wait_drained();

		// small limit: weights pin at the limit
		write_reg(pbp_pkg::REG_WEIGHT_LIMIT, 3);
		repeat (5)
			stage(pbp_pkg::REQ_TRAIN, 32'hFFFF_FFFF, 1'b1, -5, 1'b0);
		stage(pbp_pkg::REQ_PREDICT, 32'hFFFF_FFFF, 1'b0, 0, 1'b0);
		stage(pbp_pkg::REQ_PREDICT, 32'h0000_0000, 1'b0, 0, 1'b0);
		wait_drained();

		// lowered limit: old weights survive until the next applied update
		write_reg(pbp_pkg::REG_WEIGHT_LIMIT, 1);
		stage(pbp_pkg::REQ_PREDICT, 32'hFFFF_FFFF, 1'b0, 0, 1'b0);
		stage(pbp_pkg::REQ_TRAIN, 32'h0F0F_0F0F, 1'b0, -100, 1'b0);
		stage(pbp_pkg::REQ_PREDICT, 32'hFFFF_FFFF, 1'b0, 0, 1'b0);
		stage(pbp_pkg::REQ_TRAIN, 32'h0000_0000, 1'b0, 5, 1'b0);
		stage(pbp_pkg::REQ_PREDICT, 32'hFFFF_FFFF, 1'b0, 0, 1'b0);
		wait_drained();

		write_reg(pbp_pkg::REG_WEIGHT_LIMIT, 0);
		stage(pbp_pkg::REQ_TRAIN, 32'hFFFF_FFFF, 1'b1, -1, 1'b0);
		stage(pbp_pkg::REQ_PREDICT, 32'hFFFF_FFFF, 1'b0, 0, 1'b0);
		wait_drained();

		lim_plan = '{127, 127, 0, 1, 0, 127, 0, 63};
		thr_plan = '{0, 8191, 4064, 3, 0, 0, 8191, 4095};
		lim_plan[4] = int'($urandom_range(0, 127));
		lim_plan[6] = int'($urandom_range(0, 127));
		thr_plan[4] = int'($urandom_range(0, 8191));
		thr_plan[5] = int'($urandom_range(0, 200));

		for (int p = 0; p < 8; p++) begin
			write_reg(pbp_pkg::REG_WEIGHT_LIMIT, lim_plan[p]);
			write_reg(pbp_pkg::REG_TRAIN_THRESHOLD, thr_plan[p]);
			idle_on = (p % 4) != 0;
			foreach (pool[k])
				pool[k] = $urandom;
			made = 0;
			while (made < 240) begin
				if ($urandom_range(0, 9) < 8) begin
					slot = int'($urandom_range(0, 3));
					stage(pbp_pkg::REQ_PREDICT, pool[slot], 1'($urandom_range(0, 1)),
						rand_earlier(), 1'b0);
					stage(pbp_pkg::REQ_TRAIN, pool[slot],
						(slot < 2) ^ ($urandom_range(0, 7) == 0), 0, 1'b1);
					made += 2;
				end else begin
					stage(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
						rand_earlier(), 1'b0);
					made++;
				end
			end
			if (p == 2) begin
				@(posedge clk);
				hold_arm <= 1'b1;
				@(posedge clk);
				hold_arm <= 1'b0;
			end
			wait_drained();
		end

		repeat (2 * (NW + 3)) @(posedge clk);
		if (mismatch_cnt == 0 && awaited_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
